@@ rtl/core/pbm_pkg.sv @@
package pbm_pkg;

  localparam int unsigned TAG_W = 32;

  typedef enum logic [1:0] {
    OP_REQUEST    = 2'd0,
    OP_RELEASE    = 2'd1,
    OP_FLUSH_FILE = 2'd2,
    OP_FLUSH_ALL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_FREE     = 3'd1,
    ST_NOT_PINNED  = 3'd2,
    ST_PIN_OVF     = 3'd3,
    ST_PINNED_SKIP = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ_SCAN,
    S_REQ_VICTIM,
    S_REQ_HIT,
    S_REQ_MISS,
    S_RELEASE,
    S_FL_SCAN,
    S_FL_DONE
  } state_t;

  // Result fields apart from the frame number.
  typedef struct packed {
    logic             hit;
    logic             fetch;
    logic             writeback;
    logic [TAG_W-1:0] wb_file;
    logic [TAG_W-1:0] wb_page;
    status_t          status;
    logic             last;
  } res_t;

endpackage

@@ rtl/core/pbm_if.sv @@
interface pbm_in_if #(parameter int unsigned FRAME_W = 5) ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [31:0]        file_number;
  logic [31:0]        page_number;
  logic               append_flag;
  logic [FRAME_W-1:0] frame_index;
  logic               dirty_flag;

  modport source (output valid, operation, file_number, page_number, append_flag,
                  frame_index, dirty_flag, input ready);
  modport sink (input valid, operation, file_number, page_number, append_flag,
                frame_index, dirty_flag, output ready);
endinterface

interface pbm_out_if #(parameter int unsigned FRAME_W = 5) ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_number;
  logic               hit;
  logic               fetch;
  logic               writeback;
  logic [31:0]        wb_file;
  logic [31:0]        wb_page;
  logic [2:0]         status;
  logic               last;

  modport source (output valid, frame_number, hit, fetch, writeback, wb_file, wb_page,
                  status, last, input ready);
  modport sink (input valid, frame_number, hit, fetch, writeback, wb_file, wb_page,
                status, last, output ready);
endinterface

@@ rtl/core/pbm_ram.sv @@
module pbm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/page_buffer_pool_manager.sv @@
// Page buffer pool manager.
// Input channel req carries one transaction per operation: request a page,
// release a frame, flush one file or flush all. Output channel rsp carries the
// results; the final result of each operation has last set. Request and
// release give one result, a flush gives one result per matching valid frame
// in ascending frame order followed by a closing result.
// The block works on one operation at a time and drops req.ready until the
// last result has been placed in the output register. A request scans the tag
// RAM one frame per cycle and ends early on a hit; a miss then picks the
// oldest unpinned frame as victim before it gives its result. The tag RAM
// has a single read port, visited once per frame.
// The result sits in an output register; the block keeps working while it
// waits, and stops only when it has a new result and the register is still
// held by a stalled receiver.
// Reset clears all valid, dirty and pin state, puts frames 0 upward in
// release order and empties the output register. Tags need no clearing.
module page_buffer_pool_manager #(
  parameter int unsigned FRAME_COUNT = 32,
  parameter int unsigned PIN_BITS    = 8
) (
  input logic      clk,
  input logic      rst,
  pbm_in_if.sink   req,
  pbm_out_if.source rsp
);
  import pbm_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAME_COUNT);
  localparam int unsigned CNT_W = $clog2(FRAME_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  state_t state, state_next;

  // Latched operation.
  op_t              op;
  logic [TAG_W-1:0] file_q;
  logic [TAG_W-1:0] page_q;
  logic             append_q;
  logic             dirty_q;

  // k walks the frames during a scan; sel addresses a single frame otherwise.
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] sel;
  logic [IDX_W-1:0] vic;
  logic [IDX_W-1:0] aidx;
  logic             sel_in_range;

  // Per-frame state. A frame with pin count zero is in the release order list
  // and its rank is its position there, 0 being the oldest.
  logic                tag_valid   [FRAME_COUNT];
  logic                frame_dirty [FRAME_COUNT];
  logic [PIN_BITS-1:0] pin_count   [FRAME_COUNT];
  logic [IDX_W-1:0]    rank        [FRAME_COUNT];
  logic [CNT_W-1:0]    lru_length;

  // Tag RAM.
  logic                 ram_we;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [2*TAG_W-1:0]   ram_rdata;
  logic [TAG_W-1:0]     rd_file;
  logic [TAG_W-1:0]     rd_page;

  // Output register.
  logic             out_valid;
  logic [IDX_W-1:0] out_frame;
  res_t             out_res;

  logic             ofree;
  logic             in_acc;
  logic             emit;
  logic [IDX_W-1:0] emit_frame;
  res_t             emit_res;

  logic             a_valid;
  logic             a_dirty;
  logic [PIN_BITS-1:0] a_pin;
  logic [IDX_W-1:0] a_rank;
  logic             a_pin_zero;
  logic             a_pin_full;
  logic             k_last;
  logic             req_hit;
  logic             fl_match;
  logic             rel_ok;

  pbm_ram #(.WIDTH(2 * TAG_W), .DEPTH(FRAME_COUNT)) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel),
    .wdata ({file_q, page_q}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_file = ram_rdata[2*TAG_W-1:TAG_W];
  assign rd_page = ram_rdata[TAG_W-1:0];

  assign ofree  = !out_valid || rsp.ready;
  assign in_acc = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign aidx = (state == S_REQ_SCAN || state == S_FL_SCAN) ? k : sel;
  assign sel_in_range = (int'(sel) < FRAME_COUNT);

  assign a_valid    = tag_valid[aidx];
  assign a_dirty    = frame_dirty[aidx];
  assign a_pin      = pin_count[aidx];
  assign a_rank     = rank[aidx];
  assign a_pin_zero = (a_pin == '0);
  assign a_pin_full = (a_pin == '1);
  assign k_last     = (k == LAST_IDX);

  assign req_hit  = a_valid && rd_file == file_q && rd_page == page_q;
  assign fl_match = a_valid && (op == OP_FLUSH_ALL || rd_file == file_q);
  assign rel_ok   = sel_in_range && a_valid && !a_pin_zero;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (op_t'(req.operation) == OP_RELEASE) state_next = S_RELEASE;
          else if (op_t'(req.operation) == OP_REQUEST) state_next = S_REQ_SCAN;
          else state_next = S_FL_SCAN;
        end
      end
      S_REQ_SCAN: begin
        if (req_hit) state_next = S_REQ_HIT;
        else if (k_last) state_next = S_REQ_VICTIM;
      end
      S_REQ_VICTIM: begin
        if (lru_length != '0) state_next = S_REQ_MISS;
        else if (ofree) state_next = S_IDLE;
      end
      S_REQ_HIT, S_REQ_MISS, S_RELEASE, S_FL_DONE: begin
        if (ofree) state_next = S_IDLE;
      end
      S_FL_SCAN: begin
        if ((!fl_match || ofree) && k_last) state_next = S_FL_DONE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Tag RAM control and result selection.
  always_comb begin
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    emit       = 1'b0;
    emit_frame = '0;
    emit_res   = '0;
    unique case (state)
      S_IDLE: begin
        ram_re = in_acc;
      end
      S_REQ_SCAN: begin
        ram_re    = !req_hit && !k_last;
        ram_raddr = k + 1'b1;
      end
      S_REQ_VICTIM: begin
        ram_re    = (lru_length != '0);
        ram_raddr = vic;
        if (lru_length == '0) begin
          emit            = ofree;
          emit_res.status = ST_NO_FREE;
          emit_res.last   = 1'b1;
        end
      end
      S_REQ_HIT: begin
        emit            = ofree;
        emit_frame      = sel;
        emit_res.hit    = 1'b1;
        emit_res.status = a_pin_full ? ST_PIN_OVF : ST_OK;
        emit_res.last   = 1'b1;
      end
      S_REQ_MISS: begin
        emit               = ofree;
        ram_we             = ofree;
        emit_frame         = sel;
        emit_res.fetch     = !append_q;
        emit_res.writeback = a_valid && a_dirty;
        emit_res.wb_file   = (a_valid && a_dirty) ? rd_file : '0;
        emit_res.wb_page   = (a_valid && a_dirty) ? rd_page : '0;
        emit_res.status    = ST_OK;
        emit_res.last      = 1'b1;
      end
      S_RELEASE: begin
        emit            = ofree;
        emit_frame      = sel;
        emit_res.status = rel_ok ? ST_OK : ST_NOT_PINNED;
        emit_res.last   = 1'b1;
      end
      S_FL_SCAN: begin
        ram_re     = (!fl_match || ofree) && !k_last;
        ram_raddr  = k + 1'b1;
        emit       = fl_match && ofree;
        emit_frame = k;
        if (!a_pin_zero) begin
          emit_res.status = ST_PINNED_SKIP;
        end else begin
          emit_res.status    = ST_OK;
          emit_res.writeback = a_dirty;
          emit_res.wb_file   = a_dirty ? rd_file : '0;
          emit_res.wb_page   = a_dirty ? rd_page : '0;
        end
      end
      S_FL_DONE: begin
        emit            = ofree;
        emit_res.status = ST_OK;
        emit_res.last   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control registers, frame state and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      lru_length <= CNT_W'(FRAME_COUNT);
      for (int j = 0; j < FRAME_COUNT; j++) begin
        tag_valid[j]   <= 1'b0;
        frame_dirty[j] <= 1'b0;
        pin_count[j]   <= '0;
        rank[j]        <= IDX_W'(j);
      end
    end else begin
      state <= state_next;

      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            op       <= op_t'(req.operation);
            file_q   <= req.file_number;
            page_q   <= req.page_number;
            append_q <= req.append_flag;
            dirty_q  <= req.dirty_flag;
            sel      <= req.frame_index;
            k        <= '0;
          end
        end
        S_REQ_SCAN: begin
          if (a_pin_zero && a_rank == '0) vic <= k;
          if (req_hit) sel <= k;
          else if (!k_last) k <= k + 1'b1;
        end
        S_REQ_VICTIM: begin
          sel <= vic;
        end
        S_REQ_HIT, S_REQ_MISS: begin
          if (ofree && !(state == S_REQ_HIT && a_pin_full)) begin
            if (a_pin_zero) begin
              // Leaving the release order list: close the gap behind it.
              for (int j = 0; j < FRAME_COUNT; j++) begin
                if (rank[j] > a_rank) rank[j] <= rank[j] - 1'b1;
              end
              lru_length <= lru_length - 1'b1;
            end
            pin_count[aidx] <= a_pin + 1'b1;
            if (state == S_REQ_MISS) begin
              tag_valid[aidx]   <= 1'b1;
              frame_dirty[aidx] <= append_q;
            end
          end
        end
        S_RELEASE: begin
          if (ofree && rel_ok) begin
            pin_count[aidx] <= a_pin - 1'b1;
            if (dirty_q) frame_dirty[aidx] <= 1'b1;
            if (a_pin == PIN_BITS'(1)) begin
              rank[aidx] <= lru_length[IDX_W-1:0];
              lru_length <= lru_length + 1'b1;
            end
          end
        end
        S_FL_SCAN: begin
          if (emit && a_pin_zero) begin
            tag_valid[aidx]   <= 1'b0;
            frame_dirty[aidx] <= 1'b0;
          end
          if ((!fl_match || ofree) && !k_last) k <= k + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_frame <= emit_frame;
      out_res   <= emit_res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.frame_number = out_frame;
  assign rsp.hit          = out_res.hit;
  assign rsp.fetch        = out_res.fetch;
  assign rsp.writeback    = out_res.writeback;
  assign rsp.wb_file      = out_res.wb_file;
  assign rsp.wb_page      = out_res.wb_page;
  assign rsp.status       = out_res.status;
  assign rsp.last         = out_res.last;

endmodule

@@ rtl/core/pbm_checker.sv @@
module pbm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       hit,
  input logic       writeback,
  input logic [2:0] status,
  input logic       last
);
  import pbm_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // One operation at a time: no acceptance right after an acceptance.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  // Results ahead of the final one come only from flushes.
  a_flush_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (status == ST_OK || status == ST_PINNED_SKIP) && !hit)
    else $error("bad intermediate result");

  // A write-back never comes with a hit or an error.
  a_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid && writeback |-> status == ST_OK && !hit)
    else $error("write-back with hit or error");

endmodule

bind page_buffer_pool_manager pbm_checker u_pbm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .hit       (rsp.hit),
  .writeback (rsp.writeback),
  .status    (rsp.status),
  .last      (rsp.last)
);
